/* design/vda_pkg.sv */
// Shared types, widths and constants for the vector distance and angle block.
package vda_pkg;

  localparam int COORD_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int DIST_FRAC = 4;
  localparam int DIST_W    = COORD_W + 1 + DIST_FRAC;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int SUM_W     = SQ_W + 1;
  localparam int RAD_W     = 2 * DIST_W;
  localparam int REM_W     = DIST_W + 3;

  localparam int NORM_BIT  = 40;
  localparam int NORM_W    = NORM_BIT + 1;
  localparam int NSH       = $clog2(NORM_W);
  localparam int NSH_SPLIT = NSH / 2;

  localparam int CX_W         = NORM_BIT + 5;
  localparam int TURN_BITS    = 32;
  localparam int Z_W          = TURN_BITS;
  localparam int FULL_W       = TURN_BITS + 1;
  localparam int CORDIC_STEPS = 30;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [TURN_BITS-1:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81, 41,
    20, 10, 5, 3, 1
  };

  localparam int FRONT_LAT      = 4;
  localparam int ANGLE_CORE_LAT = CORDIC_STEPS + 2;
  localparam int DIST_CORE_LAT  = DIST_W + 1;
  localparam int CORE_LAT       = (ANGLE_CORE_LAT > DIST_CORE_LAT) ?
                                  ANGLE_CORE_LAT : DIST_CORE_LAT;
  localparam int ANGLE_PAD      = CORE_LAT - ANGLE_CORE_LAT;
  localparam int DIST_PAD       = CORE_LAT - DIST_CORE_LAT;
  localparam int LATENCY        = FRONT_LAT + CORE_LAT;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
  } vda_in_t;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] angle;
  } vda_out_t;

  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic coincide;
  } vda_quad_t;

endpackage

/* design/vda_delay.sv */
// Valid-tagged delay line used to line up the two result paths.
module vda_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] data [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld[0] <= in_valid;
      for (int p = 1; p < DEPTH; p++) begin
        vld[p] <= vld[p-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      data[0] <= in_data;
    end
    for (int p = 1; p < DEPTH; p++) begin
      if (vld[p-1]) begin
        data[p] <= data[p-1];
      end
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign out_data  = data[DEPTH-1];

endmodule

/* design/vda_front.sv */
// Front stages: differences, magnitudes, squares and CORDIC input normalisation.
module vda_front
  import vda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  vda_in_t           points,
  output logic              out_valid,
  output vda_quad_t         quad,
  output logic [RAD_W-1:0]  radicand,
  output logic [NORM_W-1:0] norm_x,
  output logic [NORM_W-1:0] norm_y
);

  logic [FRONT_LAT-1:0]     vld;
  logic signed [DIFF_W-1:0] dx, dy, dx_next, dy_next;
  logic [COORD_W-1:0]       ax, ay, ax_next, ay_next;
  vda_quad_t                quad_next, quad_s2, quad_s3;
  logic [SQ_W-1:0]          sq_x, sq_y;
  logic [SUM_W-1:0]         sum;
  logic [RAD_W-1:0]         rad_next;
  logic [NORM_W-1:0]        half_x, half_y, half_x_next, half_y_next;
  logic [NORM_W-1:0]        norm_x_next, norm_y_next;

  assign dx_next = {points.target_x[COORD_W-1], points.target_x}
                 - {points.origin_x[COORD_W-1], points.origin_x};
  assign dy_next = {points.target_y[COORD_W-1], points.target_y}
                 - {points.origin_y[COORD_W-1], points.origin_y};

  assign ax_next = dx[DIFF_W-1] ? COORD_W'(-dx) : COORD_W'(dx);
  assign ay_next = dy[DIFF_W-1] ? COORD_W'(-dy) : COORD_W'(dy);

  assign quad_next.dx_neg   = dx[DIFF_W-1];
  assign quad_next.dy_neg   = dy[DIFF_W-1];
  assign quad_next.dx_zero  = (dx == '0);
  assign quad_next.coincide = (dx == '0) && (dy == '0);

  // normalise: largest shifts first, larger of x and y ends up on NORM_BIT
  always_comb begin
    half_x_next = NORM_W'(ax);
    half_y_next = NORM_W'(ay);
    for (int k = NSH - 1; k >= NSH_SPLIT; k--) begin
      if (((half_x_next | half_y_next) >> (NORM_W - (1 << k))) == '0) begin
        half_x_next = half_x_next << (1 << k);
        half_y_next = half_y_next << (1 << k);
      end
    end
  end

  always_comb begin
    norm_x_next = half_x;
    norm_y_next = half_y;
    for (int k = NSH_SPLIT - 1; k >= 0; k--) begin
      if (((norm_x_next | norm_y_next) >> (NORM_W - (1 << k))) == '0) begin
        norm_x_next = norm_x_next << (1 << k);
        norm_y_next = norm_y_next << (1 << k);
      end
    end
  end

  assign sum      = SUM_W'(sq_x) + SUM_W'(sq_y);
  assign rad_next = RAD_W'(sum) << (2 * DIST_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FRONT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (vld[0]) begin
      ax      <= ax_next;
      ay      <= ay_next;
      quad_s2 <= quad_next;
    end
    if (vld[1]) begin
      sq_x    <= ax * ax;
      sq_y    <= ay * ay;
      half_x  <= half_x_next;
      half_y  <= half_y_next;
      quad_s3 <= quad_s2;
    end
    if (vld[2]) begin
      radicand <= rad_next;
      norm_x   <= norm_x_next;
      norm_y   <= norm_y_next;
      quad     <= quad_s3;
    end
  end

  assign out_valid = vld[FRONT_LAT-1];

endmodule

/* design/vda_cordic.sv */
// Pipelined vectoring CORDIC with quadrant placement and angle rounding.
module vda_cordic
  import vda_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  vda_quad_t          quad,
  input  logic [NORM_W-1:0]  norm_x,
  input  logic [NORM_W-1:0]  norm_y,
  output logic               out_valid,
  output logic [ANGLE_W-1:0] angle
);

  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(1) << (TURN_BITS - 2);
  localparam logic [FULL_W-1:0] HALF_TURN = FULL_W'(1) << (TURN_BITS - 1);
  localparam logic [FULL_W-1:0] FULL_TURN = FULL_W'(1) << TURN_BITS;
  localparam logic [FULL_W-1:0] ROUND_ADD = FULL_W'(1) << (TURN_BITS - 1 - ANGLE_W);

  logic [CORDIC_STEPS:0]    vld;
  logic [CORDIC_STEPS:1]    vld_q;
  logic signed [CX_W-1:0]   cx [0:CORDIC_STEPS-2];
  logic signed [CX_W-1:0]   cy [0:CORDIC_STEPS-1];
  logic signed [Z_W-1:0]    z  [0:CORDIC_STEPS];
  vda_quad_t                side [0:CORDIC_STEPS];

  logic [TURN_BITS-2:0]     a_clamp;
  logic [FULL_W-1:0]        full_next, full_q, rounded;
  logic                     coin_q, vld_a;
  vda_quad_t                s_fin;

  assign vld     = {vld_q, in_valid};
  assign cx[0]   = CX_W'(norm_x);
  assign cy[0]   = CX_W'(norm_y);
  assign z[0]    = '0;
  assign side[0] = quad;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld[CORDIC_STEPS-1:0];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic [CX_W-1:0]       LOW_MASK = {CX_W{1'b1}} >> (CX_W - i);
    localparam logic signed [Z_W-1:0] ATAN_Z   = Z_W'(ATAN_TURN[i]);
    logic down;

    // rotate clockwise while y is non-negative
    assign down = !cy[i][CX_W-1];

    always_ff @(posedge clk) begin
      if (vld[i]) begin
        z[i+1]    <= down ? z[i] + ATAN_Z : z[i] - ATAN_Z;
        side[i+1] <= side[i];
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_y
      logic                   fix_x;
      logic signed [CX_W-1:0] xs;
      // shift of a negative value rounds towards zero
      assign fix_x = cx[i][CX_W-1] && ((cx[i] & LOW_MASK) != '0);
      assign xs    = (cx[i] >>> i) + $signed({{(CX_W-1){1'b0}}, fix_x});
      always_ff @(posedge clk) begin
        if (vld[i]) begin
          cy[i+1] <= down ? cy[i] - xs : cy[i] + xs;
        end
      end
    end

    if (i < CORDIC_STEPS - 2) begin : g_x
      logic                   fix_y;
      logic signed [CX_W-1:0] ys;
      assign fix_y = cy[i][CX_W-1] && ((cy[i] & LOW_MASK) != '0);
      assign ys    = (cy[i] >>> i) + $signed({{(CX_W-1){1'b0}}, fix_y});
      always_ff @(posedge clk) begin
        if (vld[i]) begin
          cx[i+1] <= down ? cx[i] + ys : cx[i] - ys;
        end
      end
    end
  end

  assign s_fin = side[CORDIC_STEPS];

  always_comb begin
    priority if (z[CORDIC_STEPS][Z_W-1]) begin
      a_clamp = '0;
    end else if (z[CORDIC_STEPS] > Z_QUARTER) begin
      a_clamp = (TURN_BITS-1)'(Z_QUARTER);
    end else begin
      a_clamp = z[CORDIC_STEPS][TURN_BITS-2:0];
    end
  end

  always_comb begin
    priority if (!s_fin.dy_neg && !s_fin.dx_neg) begin
      full_next = FULL_W'(a_clamp);
    end else if (!s_fin.dy_neg) begin
      full_next = HALF_TURN - FULL_W'(a_clamp);
    end else if (s_fin.dx_neg || s_fin.dx_zero) begin
      full_next = HALF_TURN + FULL_W'(a_clamp);
    end else begin
      full_next = FULL_TURN - FULL_W'(a_clamp);
    end
  end

  assign rounded = full_q + ROUND_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a     <= vld[CORDIC_STEPS];
      out_valid <= vld_a;
    end
  end

  always_ff @(posedge clk) begin
    if (vld[CORDIC_STEPS]) begin
      full_q <= full_next;
      coin_q <= s_fin.coincide;
    end
    if (vld_a) begin
      // a full turn wraps to zero by dropping the top bit
      angle <= coin_q ? '0 : rounded[TURN_BITS-1 -: ANGLE_W];
    end
  end

endmodule

/* design/vda_sqrt.sv */
// Pipelined digit-by-digit square root, one root bit per stage, rounded to nearest.
module vda_sqrt
  import vda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  radicand,
  output logic              out_valid,
  output logic [DIST_W-1:0] distance
);

  localparam int N = DIST_W;

  logic [N:0]        vld;
  logic [N:1]        vld_q;
  logic [RAD_W-1:0]  rad  [0:N-1];
  logic [REM_W-1:0]  rem  [0:N];
  logic [DIST_W-1:0] root [0:N];

  assign vld     = {vld_q, in_valid};
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign root[0] = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_q     <= vld[N-1:0];
      out_valid <= vld[N];
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_bit
    logic [REM_W-1:0] rem_s, trial;
    logic             ge;

    assign rem_s = {rem[j][REM_W-3:0], rad[j][RAD_W-1 -: 2]};
    assign trial = REM_W'({root[j], 2'b01});
    assign ge    = (rem_s >= trial);

    always_ff @(posedge clk) begin
      if (vld[j]) begin
        rem[j+1]  <= ge ? rem_s - trial : rem_s;
        root[j+1] <= {root[j][DIST_W-2:0], ge};
      end
    end

    if (j < N - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (vld[j]) begin
          rad[j+1] <= rad[j] << 2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld[N]) begin
      distance <= (rem[N] > REM_W'(root[N])) ? root[N] + DIST_W'(1) : root[N];
    end
  end

endmodule

/* design/vector_distance_and_angle.sv */
// Top level: distance and direction between two points, fully pipelined.
//
// Channel  Ports                  Transfer
// input    start, busy, points    clk rise with start high and busy low
// output   done, result           clk rise ending the single cycle done is high
//
// One point pair may be taken every cycle; done follows a transfer through
// 4 front stages (differences, squares, normalisation), 30 CORDIC stages and
// 2 angle finishing stages; the 22-stage root path is padded to match.
// rst is synchronous and clears all valid bits; items in flight are dropped.
// busy is high only in the cycle after a reset edge. Results cannot be held off.
module vector_distance_and_angle
  import vda_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  vda_in_t  points,
  output logic     busy,
  output logic     done,
  output vda_out_t result
);

  logic               accept;
  logic               f_valid;
  vda_quad_t          f_quad;
  logic [RAD_W-1:0]   f_rad;
  logic [NORM_W-1:0]  f_norm_x, f_norm_y;
  logic               c_valid, s_valid, a_valid, d_valid;
  logic [ANGLE_W-1:0] c_angle, a_angle;
  logic [DIST_W-1:0]  s_dist, d_dist;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  vda_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .points   (points),
    .out_valid(f_valid),
    .quad     (f_quad),
    .radicand (f_rad),
    .norm_x   (f_norm_x),
    .norm_y   (f_norm_y)
  );

  vda_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .quad     (f_quad),
    .norm_x   (f_norm_x),
    .norm_y   (f_norm_y),
    .out_valid(c_valid),
    .angle    (c_angle)
  );

  vda_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .radicand (f_rad),
    .out_valid(s_valid),
    .distance (s_dist)
  );

  if (ANGLE_PAD > 0) begin : g_angle_pad
    vda_delay #(.WIDTH(ANGLE_W), .DEPTH(ANGLE_PAD)) u_angle_pad (
      .clk      (clk),
      .rst      (rst),
      .in_valid (c_valid),
      .in_data  (c_angle),
      .out_valid(a_valid),
      .out_data (a_angle)
    );
  end else begin : g_angle_direct
    assign a_valid = c_valid;
    assign a_angle = c_angle;
  end

  if (DIST_PAD > 0) begin : g_dist_pad
    vda_delay #(.WIDTH(DIST_W), .DEPTH(DIST_PAD)) u_dist_pad (
      .clk      (clk),
      .rst      (rst),
      .in_valid (s_valid),
      .in_data  (s_dist),
      .out_valid(d_valid),
      .out_data (d_dist)
    );
  end else begin : g_dist_direct
    assign d_valid = s_valid;
    assign d_dist  = s_dist;
  end

  // both halves arrive together
  assign done            = a_valid && d_valid;
  assign result.distance = d_dist;
  assign result.angle    = a_angle;

endmodule

/* design/vda_checker.sv */
// Port-level checks for vector_distance_and_angle and the bind that attaches them.
module vda_checker
  import vda_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input vda_out_t result
);

  logic accept;

  assign accept = start && !busy;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("transfer not answered after fixed latency");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without matching input transfer");

  a_coincide: assert property (@(posedge clk) disable iff (rst)
    (done && (result.distance == '0)) |-> (result.angle == '0))
    else $error("zero distance with non-zero angle");

  a_reset: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("reset did not clear pipeline");

  a_ready: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy outside reset");

endmodule

bind vector_distance_and_angle vda_checker u_vda_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);
